// ----- rtl/sac_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the set-associative cache tag controller.
// Used by every module under rtl/ except sac_ram; depends on nothing else.
package sac_pkg;

    // Geometry of the cache.
    localparam int NUM_SETS     = 16;
    localparam int NUM_WAYS     = 8;
    localparam int ADDRESS_BITS = 16;

    // Address layout: the set field is bits 5..2, the tag starts at bit 6.
    localparam int SET_SHIFT      = 2;
    localparam int TAG_SHIFT      = 6;
    localparam int SET_FIELD_BITS = TAG_SHIFT - SET_SHIFT;
    localparam int SET_FIELD_MAX  = (1 << SET_FIELD_BITS) - 1;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int AGE_W  = $clog2(NUM_WAYS);
    localparam int TAG_W  = ADDRESS_BITS - TAG_SHIFT;

    // Width used while folding the set field into the set range.
    localparam int SET_CALC_W = (SET_FIELD_BITS > SET_W + 1) ? SET_FIELD_BITS : SET_W + 1;
    localparam int SET_FOLD_STEPS = SET_FIELD_MAX / NUM_SETS;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef logic [SET_W-1:0]    set_idx_t;
    typedef logic [WAY_W-1:0]    way_idx_t;
    typedef logic [AGE_W-1:0]    age_t;
    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [NUM_WAYS-1:0] way_vec_t;
    typedef age_t [NUM_WAYS-1:0] age_row_t;
    typedef tag_t [NUM_WAYS-1:0] tag_row_t;

    localparam age_t AGE_YOUNGEST = AGE_W'(NUM_WAYS - 1);

    // Per-set bookkeeping that lives in flip-flops.
    typedef struct packed {
        way_vec_t valid;
        way_vec_t dirty;
        age_row_t age;
    } set_meta_t;

    // What one read reports.
    typedef struct packed {
        logic hit;
        logic dirty;
    } sac_result_t;

    // Reduces the 4-bit set field to the set range by repeated subtraction.
    function automatic set_idx_t set_index(input logic [SET_FIELD_BITS-1:0] field);
        logic [SET_CALC_W-1:0] v;
        v = SET_CALC_W'(field);
        for (int i = 0; i < SET_FOLD_STEPS; i++) begin
            if (v >= SET_CALC_W'(NUM_SETS)) begin
                v = v - SET_CALC_W'(NUM_SETS);
            end
        end
        return v[SET_W-1:0];
    endfunction

endpackage

// ----- rtl/sac_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Stand-alone; no package dependency.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sac_lookup.sv -----
`timescale 1ns / 1ps
// Tag compare, victim choice and LRU/dirty update for one set, all combinational.
// Depends on sac_pkg.
module sac_lookup (
    input  sac_pkg::cmd_t        cmd,
    input  sac_pkg::tag_t        tag,
    input  sac_pkg::tag_row_t    tag_row,
    input  sac_pkg::set_meta_t   meta,
    output sac_pkg::tag_row_t    tag_row_next,
    output sac_pkg::set_meta_t   meta_next,
    output sac_pkg::sac_result_t result
);
    import sac_pkg::*;

    way_vec_t hit_vec;
    logic     hit;
    way_idx_t hit_way;
    way_idx_t victim_way;
    way_idx_t sel_way;
    logic     hit_found;
    logic     victim_found;
    age_t     old_age;

    always_comb begin
        hit_way      = '0;
        victim_way   = '0;
        hit_found    = 1'b0;
        victim_found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            hit_vec[w] = meta.valid[w] && (tag_row[w] == tag);
            if (hit_vec[w] && !hit_found) begin
                hit_way   = WAY_W'(w);
                hit_found = 1'b1;
            end
            if ((meta.age[w] == '0) && !victim_found) begin
                victim_way   = WAY_W'(w);
                victim_found = 1'b1;
            end
        end
        hit     = |hit_vec;
        sel_way = hit ? hit_way : victim_way;
        old_age = meta.age[sel_way];
    end

    always_comb begin
        tag_row_next = tag_row;
        meta_next    = meta;
        // The touched way becomes youngest; every way younger than it ages by one.
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == sel_way) begin
                meta_next.age[w] = AGE_YOUNGEST;
            end else if (meta.age[w] > old_age) begin
                meta_next.age[w] = meta.age[w] - age_t'(1);
            end
        end
        meta_next.valid[sel_way] = 1'b1;
        tag_row_next[sel_way]    = tag;
        if (cmd == CMD_WRITE) begin
            meta_next.dirty[sel_way] = 1'b1;
        end else if (!hit) begin
            meta_next.dirty[sel_way] = 1'b0;
        end
        result.hit   = hit;
        result.dirty = meta.dirty[sel_way];
    end

endmodule

// ----- rtl/set_assoc_cache_lru_tags_top.sv -----
`timescale 1ns / 1ps
// Top level of the 16-set, 8-way write-back cache tag controller with true LRU replacement.
// Depends on sac_pkg, sac_ram and sac_lookup.
//
// Usage:
//   Requests enter on the s_ channel: s_tdata carries the byte address, s_tuser the access
//   kind (0 read, 1 write). Every read produces one response on the m_ channel with the
//   hit flag and the dirty flag (on a miss, the dirty bit of the evicted line, meaning a
//   write-back is needed). Writes update the tags but produce no response.
//   Pipeline: a read accepted at one clock edge is held in the input register and processed
//   at the next edge at which the output register is free; its response is valid right
//   after that edge. Throughput: one request per cycle when not stalled. Each request is
//   handled by a single pass through the tag compare and LRU update logic; the tag RAM
//   read is issued as the request is accepted, and a forwarding register covers
//   back-to-back requests to the same set.
//   Reset: all lines become invalid and clean, ages restart at the way number. Tags need
//   no clearing because an invalid line never compares. No clearing pass is required.
//   Stall: when m_tready is low with a response waiting, s_tready drops and the request
//   in the input register holds until the response is taken.
module set_assoc_cache_lru_tags_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sac_pkg::IN_TDATA_W-1:0]   s_tdata,  // [15:0] address
    input  logic                             s_tuser,  // [0] cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sac_pkg::OUT_TDATA_W-1:0]  m_tdata   // [0] hit, [1] dirty, rest zero
);
    import sac_pkg::*;

    // Input register.
    logic     in_valid_reg;
    cmd_t     in_cmd_reg;
    set_idx_t in_set_reg;
    tag_t     in_tag_reg;

    // Output register.
    logic        out_valid_reg;
    sac_result_t out_res_reg;

    // Per-set bookkeeping in flip-flops.
    set_meta_t meta_reg [NUM_SETS];

    // Tag forwarding for a read that collided with the write of the same set.
    logic     fwd_valid_reg;
    tag_row_t fwd_row_reg;

    logic        adv;
    logic        proc;
    set_idx_t    s_set;
    tag_t        s_tag;
    set_idx_t    ram_raddr;
    tag_row_t    ram_rdata;
    tag_row_t    tag_row;
    tag_row_t    tag_row_next;
    set_meta_t   meta_cur;
    set_meta_t   meta_next;
    sac_result_t result;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign proc     = in_valid_reg && adv;

    assign s_set = set_index(s_tdata[SET_SHIFT +: SET_FIELD_BITS]);
    assign s_tag = s_tdata[ADDRESS_BITS-1:TAG_SHIFT];

    // While stalled the held request re-reads its own set so the RAM output stays aligned.
    assign ram_raddr = adv ? s_set : in_set_reg;

    sac_ram #(
        .WIDTH ($bits(tag_row_t)),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (proc),
        .waddr (in_set_reg),
        .wdata (tag_row_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tag_row  = fwd_valid_reg ? fwd_row_reg : ram_rdata;
    assign meta_cur = meta_reg[in_set_reg];

    sac_lookup u_lookup (
        .cmd          (in_cmd_reg),
        .tag          (in_tag_reg),
        .tag_row      (tag_row),
        .meta         (meta_cur),
        .tag_row_next (tag_row_next),
        .meta_next    (meta_next),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                in_valid_reg  <= s_tvalid;
                out_valid_reg <= in_valid_reg && (in_cmd_reg == CMD_READ);
            end
            fwd_valid_reg <= proc && (ram_raddr == in_set_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_set_reg <= s_set;
            in_tag_reg <= s_tag;
        end
        if (proc) begin
            out_res_reg <= result;
        end
        fwd_row_reg <= tag_row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                meta_reg[s].valid <= '0;
                meta_reg[s].dirty <= '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    meta_reg[s].age[w] <= AGE_W'(w);
                end
            end
        end else if (proc) begin
            meta_reg[in_set_reg] <= meta_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_res_reg.dirty, out_res_reg.hit});

endmodule

// ----- rtl/sac_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the cache tag controller, bound to the top level below.
// Depends on sac_pkg and set_assoc_cache_lru_tags_top.
module sac_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [sac_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sac_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import sac_pkg::*;

    logic s_acc_rd;
    assign s_acc_rd = s_tvalid && s_tready && (s_tuser == CMD_READ);

    // Reset leaves no response pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("response valid right after reset");

    // A stalled response holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled response changed");

    // With the receiver ready, an accepted read yields a valid response.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc_rd ##1 m_tready |=> m_tvalid)
        else $error("read response missing");

    // A read directly after a read of the same address must hit (exercises forwarding).
    a_repeat_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc_rd ##1 (s_acc_rd && (s_tdata == $past(s_tdata)) && m_tready) ##1 m_tready
        |=> m_tvalid && m_tdata[0])
        else $error("repeated read did not hit");

endmodule

bind set_assoc_cache_lru_tags_top sac_checker u_sac_checker (.*);

// ----- test/tb_set_assoc_cache_lru_tags_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 16-set, 8-way LRU write-back cache tag controller.
// Depends on sac_pkg and set_assoc_cache_lru_tags_top; predicts every read response.
module tb_set_assoc_cache_lru_tags_top;
    import sac_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_OFF_LEN  = 250;

    // Receiver stall patterns.
    localparam int RX_ALWAYS     = 0;
    localparam int RX_LIGHT      = 1;
    localparam int RX_EVERY_3RD  = 2;
    localparam int RX_HEAVY      = 3;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;   // [15:0] address
    logic                     s_tuser;   // [0] cmd
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;   // [0] hit, [1] dirty

    set_assoc_cache_lru_tags_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the tag store.
    logic cache_valid [NUM_SETS][NUM_WAYS];
    tag_t cache_tag   [NUM_SETS][NUM_WAYS];
    logic cache_dirty [NUM_SETS][NUM_WAYS];
    age_t cache_age   [NUM_SETS][NUM_WAYS];

    sac_result_t read_responses_due [$];

    int     mismatches;
    int     cycle_count;
    int     burst_left;
    int     hold_off_left;
    tag_t   tag_pool [16];
    int     pool_size;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("set_assoc_cache_lru_tags_top verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, expected, got);
        mismatches++;
    endtask

    function automatic void clear_cache_model();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                cache_valid[s][w] = 1'b0;
                cache_tag[s][w]   = '0;
                cache_dirty[s][w] = 1'b0;
                cache_age[s][w]   = age_t'(w);
            end
        end
    endfunction

    // Applies one access to the shadow store; returns 1 when a read response is due.
    function automatic bit access_cache(input cmd_t cmd, input logic [ADDRESS_BITS-1:0] addr,
                                        output sac_result_t resp);
        int   set_no;
        int   way;
        bit   found;
        tag_t tag;
        age_t old_age;
        set_no = int'(addr[TAG_SHIFT-1:SET_SHIFT]) % NUM_SETS;
        tag    = tag_t'(addr >> TAG_SHIFT);
        found  = 1'b0;
        way    = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && cache_valid[set_no][w] && cache_tag[set_no][w] == tag) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (found) begin
            resp.hit   = 1'b1;
            resp.dirty = cache_dirty[set_no][way];
            if (cmd == CMD_WRITE) cache_dirty[set_no][way] = 1'b1;
        end else begin
            // The way of age zero is the least recently used one.
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (cache_age[set_no][w] == '0) way = w;
            end
            resp.hit   = 1'b0;
            resp.dirty = cache_dirty[set_no][way];
            cache_valid[set_no][way] = 1'b1;
            cache_tag[set_no][way]   = tag;
            cache_dirty[set_no][way] = (cmd == CMD_WRITE);
        end
        old_age = cache_age[set_no][way];
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (cache_age[set_no][w] > old_age) cache_age[set_no][w]--;
        end
        cache_age[set_no][way] = AGE_YOUNGEST;
        return cmd == CMD_READ;
    endfunction

    // Offers one request, waits for it to be taken, then maybe inserts an idle gap.
    task automatic send_access(input cmd_t cmd, input logic [ADDRESS_BITS-1:0] addr);
        sac_result_t resp;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(addr);
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (access_cache(cmd, addr, resp)) read_responses_due.push_back(resp);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    function automatic logic [ADDRESS_BITS-1:0] make_addr(input int set_no, input tag_t tag);
        return {tag, 4'(set_no), 2'($urandom_range(0, 3))};
    endfunction

    always @(posedge aclk) begin
        sac_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (read_responses_due.size() == 0) begin
                report_mismatch("response with no read pending, hit", -1, m_tdata[0]);
            end else begin
                due = read_responses_due.pop_front();
                if (m_tdata[0] !== due.hit) report_mismatch("hit", due.hit, m_tdata[0]);
                if (m_tdata[1] !== due.dirty) report_mismatch("dirty", due.dirty, m_tdata[1]);
            end
        end
    end

    initial begin : receiver
        int mode;
        int mode_left;
        mode      = RX_ALWAYS;
        mode_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_ALWAYS, RX_HEAVY);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:    m_tready <= 1'b1;
                    RX_LIGHT:     m_tready <= ($urandom_range(0, 3) != 0);
                    RX_EVERY_3RD: m_tready <= (mode_left % 3 != 0);
                    default:      m_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Reads and writes at the address extremes; the byte offset bits must not matter.
    task automatic test_address_extremes();
        send_access(CMD_READ,  16'h0000);
        send_access(CMD_WRITE, 16'h0000);
        send_access(CMD_READ,  16'h0003);
        send_access(CMD_READ,  16'hFFFF);
        send_access(CMD_WRITE, 16'hFFFC);
        send_access(CMD_READ,  16'hFFFE);
        send_access(CMD_READ,  16'h003C);
        send_access(CMD_READ,  16'hFFC0);
    endtask

    // Fills one set with dirty lines, refreshes the oldest, then forces evictions.
    task automatic test_lru_eviction();
        for (int t = 0; t < NUM_WAYS; t++) send_access(CMD_WRITE, make_addr(5, tag_t'(t + 1)));
        send_access(CMD_READ, make_addr(5, tag_t'(1)));
        send_access(CMD_READ, make_addr(5, tag_t'(100)));
        send_access(CMD_READ, make_addr(5, tag_t'(1)));
        send_access(CMD_READ, make_addr(5, tag_t'(3)));
        send_access(CMD_WRITE, make_addr(5, tag_t'(200)));
        send_access(CMD_READ, make_addr(5, tag_t'(4)));
        send_access(CMD_READ, make_addr(5, tag_t'(100)));
    endtask

    function automatic logic [ADDRESS_BITS-1:0] pick_address();
        if ($urandom_range(0, 99) < 85)
            return make_addr($urandom_range(0, NUM_SETS - 1),
                             tag_pool[$urandom_range(0, pool_size - 1)]);
        return ADDRESS_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    // Stops the receiver for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        hold_off_left = HOLD_OFF_LEN;
        for (int i = 0; i < 40; i++) send_access(CMD_READ, pick_address());
    endtask

    // Mostly accesses from a small working set of tags shared by all sets, so hits,
    // refreshes and evictions all happen; the rest are fully random addresses.
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                pool_size = $urandom_range(6, 16);
                for (int k = 0; k < 16; k++) tag_pool[k] = tag_t'($urandom_range(0, 1023));
            end
            send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, pick_address());
        end
    endtask

    initial begin
        mismatches    = 0;
        cycle_count   = 0;
        burst_left    = 0;
        hold_off_left = 0;
        pool_size     = 8;
        for (int k = 0; k < 16; k++) tag_pool[k] = tag_t'($urandom_range(0, 1023));
        clear_cache_model();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_READ;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_address_extremes();
        test_lru_eviction();
        test_output_backpressure();
        test_random_traffic(1600);

        s_tvalid <= 1'b0;
        while (read_responses_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("set_assoc_cache_lru_tags_top verification clean");
        end else begin
            $display("set_assoc_cache_lru_tags_top verification failed");
        end
        $finish;
    end

endmodule
